// ----- hdl/imu_complementary_attitude_filter_assert.svh -----
// assertion macros shared by the attitude filter modules
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CAF_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("imu filter assertion failed");
`define CAF_ASSERT_RST(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("imu filter assertion failed");
`else
`define CAF_ASSERT(name, clk, rst_n, prop)
`define CAF_ASSERT_RST(name, clk, prop)
`endif
`endif

// ----- hdl/imu_caf_pkg.sv -----
// types, constants and helper functions of the attitude filter
`timescale 1ns / 1ps
package imu_caf_pkg;

    localparam int DEFAULT_CORDIC_STEPS = 16;
    localparam int ATAN_LEN             = 24;
    localparam int STEP_W               = 5;
    localparam int CNT_W                = 6;
    localparam int SQRT_STEPS           = 30;
    localparam int DIV_STEPS            = 6;

    // divider phases: two radix 2^18 digits, each multiply, estimate, fix
    localparam logic [STEP_W-1:0] DIV_HI_MUL = 5'd0;
    localparam logic [STEP_W-1:0] DIV_HI_EST = 5'd1;
    localparam logic [STEP_W-1:0] DIV_HI_FIX = 5'd2;
    localparam logic [STEP_W-1:0] DIV_LO_MUL = 5'd3;
    localparam logic [STEP_W-1:0] DIV_LO_EST = 5'd4;
    localparam logic [STEP_W-1:0] DIV_LO_FIX = 5'd5;

    localparam logic signed [24:0] ANGLE_MAX = 25'sd11796480;
    localparam logic signed [25:0] DEG90     = 26'sd5898240;

    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd2;
    localparam logic [15:0] WEIGHT_RESET = 16'd64225;

    // raw * 2^17 = raw * 131000 + raw * 72, so only the small part is divided
    localparam logic signed [27:0] RATE_WHOLE    = 28'sd1000;
    localparam logic signed [23:0] RATE_FRAC     = 24'sd72;
    localparam logic signed [45:0] RATE_ROUND    = 46'sd65;
    localparam logic        [13:0] RATE_DIVISOR  = 14'd131;
    localparam logic        [24:0] RATE_RECIP    = 25'd32786009;
    // 1000000 = 64 * 15625
    localparam int                 DELTA_SHIFT   = 6;
    localparam logic        [13:0] DELTA_DIVISOR = 14'd15625;
    localparam logic        [24:0] DELTA_RECIP   = 25'd274877;
    localparam logic        [45:0] DELTA_ROUND   = 46'd500000;
    localparam logic        [45:0] BLEND_ROUND   = 46'd32768;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQ1,
        OP_SQ2,
        OP_SQRT,
        OP_CINIT,
        OP_CSTEP,
        OP_CSAVE,
        OP_RINIT,
        OP_DSTEP,
        OP_RSAVE,
        OP_DMUL,
        OP_DINIT,
        OP_DSAVE,
        OP_BMUL,
        OP_BSUM,
        OP_BSAVE,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic                axis;
        logic [STEP_W-1:0]   step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // arctangent of 2^-i in 1/65536 degree
    function automatic logic [21:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [21:0] r;
        case (i)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [24:0] sat_angle(input logic signed [31:0] v);
        logic signed [24:0] r;
        if (v > 32'(ANGLE_MAX))
            r = ANGLE_MAX;
        else if (v < -32'(ANGLE_MAX))
            r = -ANGLE_MAX;
        else
            r = v[24:0];
        return r;
    endfunction

endpackage

// ----- hdl/imu_caf_in_if.sv -----
// sample channel: one raw imu sample per beat
`timescale 1ns / 1ps
interface imu_caf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic        [15:0] step_micros;

    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, step_micros,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, step_micros,
                  output ready);
endinterface

// ----- hdl/imu_caf_out_if.sv -----
// result channel: updated roll and pitch per beat
`timescale 1ns / 1ps
interface imu_caf_out_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] roll_out;
    logic signed [24:0] pitch_out;

    modport source (output valid, roll_out, pitch_out, input ready);
    modport sink (input valid, roll_out, pitch_out, output ready);
endinterface

// ----- hdl/imu_caf_ctrl.sv -----
// sequencer that steps the datapath through one sample
`timescale 1ns / 1ps
`include "imu_complementary_attitude_filter_assert.svh"
module imu_caf_ctrl
    import imu_caf_pkg::*;
#(
    parameter int CORDIC_STEPS = DEFAULT_CORDIC_STEPS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int N_ITER = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(N_ITER - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SQ1, S_SQ2, S_SQRT, S_CINIT, S_CSTEP, S_CSAVE,
        S_RINIT, S_RDIV, S_RSAVE, S_DMUL, S_DINIT, S_DDIV, S_DSAVE,
        S_BMUL, S_BSUM, S_BSAVE, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              axis_reg, axis_next;
    dp_op_t            op;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        op         = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_SQ1;
                end
            end
            S_SQ1:
            begin
                op         = OP_SQ1;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                op         = OP_SQ2;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                op       = OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    axis_next  = 1'b0;
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                op         = OP_CINIT;
                cnt_next   = '0;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                op       = OP_CSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                    state_next = S_CSAVE;
            end
            S_CSAVE:
            begin
                op        = OP_CSAVE;
                axis_next = ~axis_reg;
                state_next = axis_reg ? S_RINIT : S_CINIT;
            end
            S_RINIT:
            begin
                op         = OP_RINIT;
                cnt_next   = '0;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                op       = OP_DSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_RSAVE;
            end
            S_RSAVE:
            begin
                op         = OP_RSAVE;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                op         = OP_DMUL;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                op         = OP_DINIT;
                cnt_next   = '0;
                state_next = S_DDIV;
            end
            S_DDIV:
            begin
                op       = OP_DSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_DSAVE;
            end
            S_DSAVE:
            begin
                op         = OP_DSAVE;
                state_next = S_BMUL;
            end
            S_BMUL:
            begin
                op         = OP_BMUL;
                state_next = S_BSUM;
            end
            S_BSUM:
            begin
                op         = OP_BSUM;
                state_next = S_BSAVE;
            end
            S_BSAVE:
            begin
                op         = OP_BSAVE;
                axis_next  = ~axis_reg;
                state_next = axis_reg ? S_DONE : S_RINIT;
            end
            S_DONE:
            begin
                // wait for the output slot to free up
                if (status.out_free)
                begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign cmd.op   = op;
    assign cmd.axis = axis_reg;
    assign cmd.step = cnt_reg[STEP_W-1:0];

    `CAF_ASSERT(a_load_start, clk, rst_n, (state_reg == S_IDLE && in_valid) |=> (state_reg == S_SQ1))
    `CAF_ASSERT(a_cordic_bound, clk, rst_n, (state_reg == S_CSTEP) |-> (cnt_reg <= CORD_LAST))
    `CAF_ASSERT(a_done_hold, clk, rst_n, (state_reg == S_DONE && !status.out_free) |=> (state_reg == S_DONE))

endmodule

// ----- hdl/imu_caf_dp.sv -----
// datapath: square root, shared cordic, constant divider, blend and output register
`timescale 1ns / 1ps
`include "imu_complementary_attitude_filter_assert.svh"
module imu_caf_dp
    import imu_caf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic signed [15:0]    accel_x,
    input  logic signed [15:0]    accel_y,
    input  logic signed [15:0]    accel_z,
    input  logic signed [15:0]    rate_x,
    input  logic signed [15:0]    rate_y,
    input  logic        [15:0]    step_micros,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [24:0]    roll_out,
    output logic signed [24:0]    pitch_out
);

    // configuration
    logic signed [17:0] bias_x_reg, bias_y_reg;
    logic        [15:0] weight_reg;

    // sample
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic        [15:0] us_reg;

    // square root
    logic [31:0] sq_reg;
    logic [59:0] rad_reg;
    logic [31:0] rem_reg;
    logic [29:0] root_reg;

    // cordic
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [25:0] cz_reg;
    logic               czero_reg;
    logic signed [24:0] acc_roll_reg, acc_pitch_reg;

    // divider
    logic [36:0] dvd_reg;
    logic [31:0] dnum_reg;
    logic [56:0] dprod_reg;
    logic [24:0] dqe_reg;
    logic [31:0] dqd_reg;
    logic [36:0] dquo_reg;
    logic [13:0] div_d_reg;
    logic [24:0] div_r_reg;
    logic        dneg_reg;

    // gyro and blend
    logic signed [27:0] rate_reg;
    logic signed [45:0] num_reg;
    logic signed [26:0] gyro_reg;
    logic signed [43:0] bprod_reg;
    logic signed [45:0] bsum_reg;
    logic signed [24:0] roll_angle_reg, pitch_angle_reg;

    logic signed [24:0] roll_out_reg, pitch_out_reg;
    logic               out_valid_reg;

    // combinational helpers
    logic [31:0]        ay_sq, az_sq;
    logic [33:0]        rem_sh, trial;
    logic               sq_ge;
    logic signed [33:0] neg_ax, xi, yi, xr, yr, xs, ys;
    logic signed [25:0] zr, atan_ext;
    logic               zero_in;
    logic signed [45:0] div_num, div_mag;
    logic [13:0]        div_d;
    logic [24:0]        div_r;
    logic [31:0]        fix_rem, fix_r;
    logic               fix_ge;
    logic [24:0]        fix_q;
    logic signed [45:0] q_s;
    logic signed [27:0] g_whole;
    logic signed [23:0] g_frac;
    logic signed [45:0] rate_sum;
    logic signed [45:0] bias_ext;
    logic signed [44:0] dprod;
    logic signed [24:0] angle_sel, acc_sel;
    logic signed [15:0] g_sel;
    logic [17:0]        w_comp;
    logic signed [43:0] prod2;

    always_comb
    begin
        ay_sq = 32'(ay_reg * ay_reg);
        az_sq = 32'(az_reg * az_reg);

        rem_sh = {rem_reg, rad_reg[59:58]};
        trial  = {2'b00, root_reg, 2'b01};
        sq_ge  = (rem_sh >= trial);

        neg_ax = -{{18{ax_reg[15]}}, ax_reg};
        if (!cmd.axis)
        begin
            yi = {{4{ay_reg[15]}}, ay_reg, 14'b0};
            xi = {{4{az_reg[15]}}, az_reg, 14'b0};
        end
        else
        begin
            yi = {neg_ax[19:0], 14'b0};
            xi = {4'b0000, root_reg};
        end
        zero_in = (xi == '0) && (yi == '0);
        // operands in the left half plane are turned by a quarter first
        if (xi < 0)
        begin
            if (yi >= 0)
            begin
                xr = yi;
                yr = -xi;
                zr = DEG90;
            end
            else
            begin
                xr = -yi;
                yr = xi;
                zr = -DEG90;
            end
        end
        else
        begin
            xr = xi;
            yr = yi;
            zr = '0;
        end

        xs       = cx_reg >>> cmd.step;
        ys       = cy_reg >>> cmd.step;
        atan_ext = $signed({4'b0000, atan_entry(cmd.step)});

        g_sel   = cmd.axis ? gy_reg : gx_reg;
        g_whole = 28'(g_sel) * RATE_WHOLE;
        g_frac  = 24'(g_sel) * RATE_FRAC;
        if (cmd.op == OP_RINIT)
        begin
            div_num = 46'(g_frac) + RATE_ROUND;
            div_d   = RATE_DIVISOR;
            div_r   = RATE_RECIP;
        end
        else
        begin
            div_num = num_reg >>> DELTA_SHIFT;
            div_d   = DELTA_DIVISOR;
            div_r   = DELTA_RECIP;
        end
        // floor division of a negative value through its offset magnitude
        if (div_num < 0)
            div_mag = -div_num + $signed({32'b0, div_d}) - 46'sd1;
        else
            div_mag = div_num;

        // the reciprocal estimate is low by at most one
        fix_rem = dnum_reg - dqd_reg;
        fix_ge  = (fix_rem >= {18'b0, div_d_reg});
        fix_q   = dqe_reg + {24'b0, fix_ge};
        fix_r   = fix_ge ? fix_rem - {18'b0, div_d_reg} : fix_rem;
        q_s     = dneg_reg ? -$signed({9'b0, dquo_reg}) : $signed({9'b0, dquo_reg});

        bias_ext = cmd.axis ? $signed({{20{bias_y_reg[17]}}, bias_y_reg, 8'b0})
                            : $signed({{20{bias_x_reg[17]}}, bias_x_reg, 8'b0});
        rate_sum = 46'(g_whole) + q_s - bias_ext;
        dprod    = rate_reg * $signed({1'b0, us_reg});

        angle_sel = cmd.axis ? pitch_angle_reg : roll_angle_reg;
        acc_sel   = cmd.axis ? acc_pitch_reg : acc_roll_reg;
        w_comp    = 18'd65536 - {2'b00, weight_reg};
        prod2     = $signed({1'b0, w_comp}) * acc_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_x_reg      <= '0;
            bias_y_reg      <= '0;
            weight_reg      <= WEIGHT_RESET;
            rem_reg         <= '0;
            root_reg        <= '0;
            div_d_reg       <= RATE_DIVISOR;
            roll_angle_reg  <= '0;
            pitch_angle_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_BIAS_X)
                    bias_x_reg <= $signed(cfg_data);
                else if (cfg_index == REG_BIAS_Y)
                    bias_y_reg <= $signed(cfg_data);
                else if (cfg_index == REG_BLEND_WEIGHT)
                    weight_reg <= cfg_data[15:0];
            end

            if (cmd.op != OP_OUT && out_ready)
                out_valid_reg <= 1'b0;

            case (cmd.op)
                OP_LOAD:
                begin
                    ax_reg   <= accel_x;
                    ay_reg   <= accel_y;
                    az_reg   <= accel_z;
                    gx_reg   <= rate_x;
                    gy_reg   <= rate_y;
                    us_reg   <= step_micros;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                OP_SQ1:
                begin
                    sq_reg <= ay_sq;
                end
                OP_SQ2:
                begin
                    rad_reg <= {sq_reg + az_sq, 28'b0};
                end
                OP_SQRT:
                begin
                    // one result bit per step
                    rad_reg <= {rad_reg[57:0], 2'b00};
                    if (sq_ge)
                    begin
                        rem_reg  <= 32'(rem_sh - trial);
                        root_reg <= {root_reg[28:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[31:0];
                        root_reg <= {root_reg[28:0], 1'b0};
                    end
                end
                OP_CINIT:
                begin
                    cx_reg    <= xr;
                    cy_reg    <= yr;
                    cz_reg    <= zr;
                    czero_reg <= zero_in;
                end
                OP_CSTEP:
                begin
                    if (cy_reg > 0)
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atan_ext;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atan_ext;
                    end
                end
                OP_CSAVE:
                begin
                    if (cmd.axis)
                        acc_pitch_reg <= czero_reg ? '0
                                       : sat_angle({{6{cz_reg[25]}}, cz_reg});
                    else
                        acc_roll_reg <= czero_reg ? '0
                                      : sat_angle({{6{cz_reg[25]}}, cz_reg});
                end
                OP_RINIT, OP_DINIT:
                begin
                    dvd_reg   <= div_mag[36:0];
                    dneg_reg  <= div_num[45];
                    div_d_reg <= div_d;
                    div_r_reg <= div_r;
                    dnum_reg  <= {13'b0, div_mag[36:18]};
                end
                OP_DSTEP:
                begin
                    case (cmd.step)
                        DIV_HI_MUL, DIV_LO_MUL:
                        begin
                            dprod_reg <= dnum_reg * div_r_reg;
                        end
                        DIV_HI_EST, DIV_LO_EST:
                        begin
                            dqe_reg <= dprod_reg[56:32];
                            dqd_reg <= 32'(dprod_reg[56:32] * div_d_reg);
                        end
                        DIV_HI_FIX:
                        begin
                            dquo_reg <= {12'b0, fix_q};
                            dnum_reg <= {fix_r[13:0], dvd_reg[17:0]};
                        end
                        DIV_LO_FIX:
                        begin
                            dquo_reg <= {dquo_reg[18:0], fix_q[17:0]};
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_RSAVE:
                begin
                    rate_reg <= rate_sum[27:0];
                end
                OP_DMUL:
                begin
                    num_reg <= $signed({dprod[44], dprod}) + $signed(DELTA_ROUND);
                end
                OP_DSAVE:
                begin
                    gyro_reg <= $signed({{2{angle_sel[24]}}, angle_sel}) + $signed(q_s[26:0]);
                end
                OP_BMUL:
                begin
                    bprod_reg <= $signed({1'b0, weight_reg}) * gyro_reg;
                end
                OP_BSUM:
                begin
                    bsum_reg <= $signed({{2{bprod_reg[43]}}, bprod_reg})
                              + $signed({{2{prod2[43]}}, prod2})
                              + $signed(BLEND_ROUND);
                end
                OP_BSAVE:
                begin
                    if (cmd.axis)
                        pitch_angle_reg <= sat_angle({{2{bsum_reg[45]}}, bsum_reg[45:16]});
                    else
                        roll_angle_reg <= sat_angle({{2{bsum_reg[45]}}, bsum_reg[45:16]});
                end
                OP_OUT:
                begin
                    roll_out_reg  <= roll_angle_reg;
                    pitch_out_reg <= pitch_angle_reg;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign roll_out        = roll_out_reg;
    assign pitch_out       = pitch_out_reg;

    `CAF_ASSERT_RST(a_sqrt_rem, clk, rem_reg <= {1'b0, root_reg, 1'b0})
    `CAF_ASSERT(a_div_digit, clk, rst_n, (cmd.op == OP_DSTEP && cmd.step == DIV_LO_MUL) |-> (dnum_reg < {div_d_reg, 18'b0}))
    `CAF_ASSERT(a_roll_range, clk, rst_n, (roll_angle_reg <= ANGLE_MAX) && (roll_angle_reg >= -ANGLE_MAX))

endmodule

// ----- hdl/imu_complementary_attitude_filter.sv -----
// top level of the roll and pitch complementary attitude filter
//
// usage:
//   sample  - valid/ready channel, one raw imu sample per beat (accelerometer
//             x/y/z, gyro x/y, elapsed microseconds)
//   result  - valid/ready channel, one beat per sample with the updated roll
//             and pitch angles in 1/65536 degree, saturated at +-180 degrees
//   cfg_*   - write port for gyro biases and blend weight, write while idle
// processing: one sample at a time, the next is taken once the result is in
//   the output register; the bulk is the 30-step square root and two cordic
//   passes on the shared unit (CORDIC_STEPS steps each, at most 24), and four
//   constant divisions of two digits, each a multiply, estimate and fix
// reset: angles go to zero, biases to zero, weight to 64225
// stall: a result waits in the output register while the next sample is
//   taken; the next result is held back until that register is emptied
`timescale 1ns / 1ps
module imu_complementary_attitude_filter
    import imu_caf_pkg::*;
#(
    parameter int CORDIC_STEPS = DEFAULT_CORDIC_STEPS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    imu_caf_in_if.sink           sample,
    imu_caf_out_if.source        result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    imu_caf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    imu_caf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .accel_x     (sample.accel_x),
        .accel_y     (sample.accel_y),
        .accel_z     (sample.accel_z),
        .rate_x      (sample.rate_x),
        .rate_y      (sample.rate_y),
        .step_micros (sample.step_micros),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .roll_out    (result.roll_out),
        .pitch_out   (result.pitch_out)
    );

endmodule

// ----- test/imu_complementary_attitude_filter_tb.sv -----
// self-checking testbench of the roll and pitch complementary attitude filter
`timescale 1ns / 1ps
module imu_complementary_attitude_filter_tb;
    import imu_caf_pkg::*;

    localparam int  N_STEPS   = DEFAULT_CORDIC_STEPS;
    localparam int  LATENCY   = 77 + 2 * N_STEPS;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [24:0] roll;
        logic signed [24:0] pitch;
    } attitude_t;

    logic clk;
    logic rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    imu_caf_in_if  sample ();
    imu_caf_out_if result ();

    imu_complementary_attitude_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample.sink),
        .result    (result.source),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state and settings
    longint    roll_q;
    longint    pitch_q;
    longint    bias_x_q;
    longint    bias_y_q;
    longint    weight_q;
    attitude_t attitude_q[$];

    int     mismatches;
    longint cycle_count = 0;
    bit     allow_idle;

    const longint ATAN_Q[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL imu_complementary_attitude_filter");
            $finish;
        end
    end

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint shr_floor(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    function automatic longint limit_angle(longint v);
        if (v > 11796480)
            return 11796480;
        if (v < -11796480)
            return -11796480;
        return v;
    endfunction

    function automatic longint sqrt_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 5898240;
            end
            else
            begin
                x = -y; y = t; z = -5898240;
            end
        end
        for (int i = 0; i < (N_STEPS > 24 ? 24 : N_STEPS); i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z += ATAN_Q[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z -= ATAN_Q[i];
            end
        end
        return limit_angle(z);
    endfunction

    function automatic longint integrate_rate(longint angle, longint raw, longint bias,
                                              longint us);
        longint rate;
        rate = fdiv(raw * 262144 + 131, 262) - bias * 256;
        return angle + fdiv(rate * us + 500000, 1000000);
    endfunction

    function automatic longint mix(longint gyro, longint acc);
        return limit_angle(fdiv(weight_q * gyro + (65536 - weight_q) * acc + 32768, 65536));
    endfunction

    task automatic predict_attitude(longint ax, longint ay, longint az, longint gx,
                                    longint gy, longint us);
        longint    mag;
        longint    tilt_roll;
        longint    tilt_pitch;
        attitude_t a;
        mag        = sqrt_floor(longint'(ay * ay + az * az) << 28);
        tilt_roll  = vector_angle(ay * 16384, az * 16384);
        tilt_pitch = vector_angle(-ax * 16384, mag);
        roll_q     = mix(integrate_rate(roll_q, gx, bias_x_q, us), tilt_roll);
        pitch_q    = mix(integrate_rate(pitch_q, gy, bias_y_q, us), tilt_pitch);
        a.roll     = roll_q[24:0];
        a.pitch    = pitch_q[24:0];
        attitude_q.push_back(a);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // result checker with random sink stalls
    always @(posedge clk)
    begin
        attitude_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (attitude_q.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                want = attitude_q.pop_front();
                if (result.roll_out !== want.roll)
                    report_mismatch("roll_out", result.roll_out, want.roll);
                if (result.pitch_out !== want.pitch)
                    report_mismatch("pitch_out", result.pitch_out, want.pitch);
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk)
    begin
        if (!allow_idle)
            result.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result.ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] gx, logic [15:0] gy, logic [15:0] us);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            sample.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample.valid       <= 1'b1;
        sample.accel_x     <= ax;
        sample.accel_y     <= ay;
        sample.accel_z     <= az;
        sample.rate_x      <= gx;
        sample.rate_y      <= gy;
        sample.step_micros <= us;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        predict_attitude(longint'($signed(ax)), longint'($signed(ay)), longint'($signed(az)),
                         longint'($signed(gx)), longint'($signed(gy)), longint'(us));
    endtask

    task automatic drain;
        @(posedge clk);
        sample.valid <= 1'b0;
        while (attitude_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BIAS_X)
            bias_x_q = value;
        else if (idx == REG_BIAS_Y)
            bias_y_q = value;
        else if (idx == REG_BLEND_WEIGHT)
            weight_q = value & 65535;
    endtask

    task automatic set_filter(longint bx, longint by, longint w);
        write_reg(REG_BIAS_X, bx);
        write_reg(REG_BIAS_Y, by);
        write_reg(REG_BLEND_WEIGHT, w);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes, zero vector, half turn and saturation
    task automatic test_directed;
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
        send_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'd1000);
        send_sample(16'h0000, 16'h0100, 16'h8000, 16'h0000, 16'h0000, 16'd1000);
        send_sample(16'h0000, 16'hff00, 16'h8000, 16'h0000, 16'h0000, 16'd1000);
        send_sample(16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'hffff);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'hffff);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'hffff);
        send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h5555);
        send_sample(16'h0001, 16'h0000, 16'h4000, 16'h0041, 16'hffbf, 16'haaaa);
        repeat (6)
            send_sample(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'hffff);
        drain();
        set_filter(131071, -131072, 65535);
        repeat (4)
            send_sample(16'h7fff, 16'h0000, 16'h8000, 16'h8000, 16'h7fff, 16'hffff);
        drain();
        set_filter(-131072, 131071, 0);
        send_sample(16'h1234, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 16'hffff);
        send_sample(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'd0);
        drain();
        // index above the register list must be ignored
        cfg_wr_en <= 1'b1;
        cfg_index <= 2'd3;
        cfg_data  <= 18'h3ffff;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        send_sample(16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'd2000);
        drain();
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_sample(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                        ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                      16'($urandom_range(500, 1500)));
    endtask

    task automatic test_settings;
        set_filter(0, 0, 64225);
        test_random(200);
        drain();
        set_filter($signed($urandom_range(0, 262143)) - 131072,
                   $signed($urandom_range(0, 262143)) - 131072, $urandom_range(0, 65535));
        test_random(200);
        drain();
        set_filter(-1, 1, 32768);
        test_random(150);
        drain();
        allow_idle = 1'b0;
        set_filter(256, -256, 65535);
        test_random(150);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        mismatches         = 0;
        allow_idle         = 1'b1;
        sample.valid       = 1'b0;
        sample.accel_x     = '0;
        sample.accel_y     = '0;
        sample.accel_z     = '0;
        sample.rate_x      = '0;
        sample.rate_y      = '0;
        sample.step_micros = '0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        roll_q             = 0;
        pitch_q            = 0;
        bias_x_q           = 0;
        bias_y_q           = 0;
        weight_q           = 64225;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_settings();
        drain();
        repeat (LATENCY) @(posedge clk);

        if (mismatches == 0 && attitude_q.size() == 0)
            $display("PASS imu_complementary_attitude_filter");
        else
            $display("FAIL imu_complementary_attitude_filter");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/imu_caf_pkg.sv
hdl/imu_caf_in_if.sv
hdl/imu_caf_out_if.sv
hdl/imu_caf_ctrl.sv
hdl/imu_caf_dp.sv
hdl/imu_complementary_attitude_filter.sv
test/imu_complementary_attitude_filter_tb.sv
